[hdl/integer_tableau_pivot_defines.svh]
// Assertion macros shared by the integer tableau pivot modules.
`ifndef INTEGER_TABLEAU_PIVOT_DEFINES_SVH
`define INTEGER_TABLEAU_PIVOT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/itp_pkg.sv]
// Shared types, constants and helpers for the integer tableau pivot block.
package itp_pkg;

    localparam int ROW_LEN_DEF  = 32;
    localparam int MAX_ROWS_DEF = 64;
    localparam int CFG_AW       = 4;
    localparam int CFG_DW       = 32;

    typedef struct packed {
        logic signed [15:0] value;
        logic               starts_matrix;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] value_out;
        logic               last_of_row;
        logic               last_of_matrix;
        logic               no_overflow;
    } t_out_item;

    typedef struct packed {
        logic [4:0] pivot_col;
        logic [6:0] rows_in_use;
        logic       ovf_detect;
        logic       skip_zero_rows;
    } t_cfg;

    // Per-row tags latched by the output side when a row is handed over.
    typedef struct packed {
        logic last_mat;
        logic ok;
    } t_emit_meta;

    // Operands of one lane for the compute pass.
    typedef struct packed {
        logic               v;
        logic               ovr;
        logic signed [15:0] x;
        logic signed [15:0] a;
        logic signed [15:0] c;
        logic signed [15:0] pj;
        logic signed [31:0] cp;
    } t_lane_op;

    typedef struct packed {
        logic               v;
        logic               ovf;
        logic signed [15:0] res;
    } t_lane_out;

    // True when a 32-bit value does not fit a signed 16-bit field.
    function automatic logic out16(input logic signed [31:0] v);
        return (v != {{16{v[15]}}, v[15:0]});
    endfunction

endpackage

[hdl/itp_cfg.sv]
// APB register file holding the pivot configuration.
module itp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itp_pkg::CFG_AW-1:0]  paddr,
    input  logic [itp_pkg::CFG_DW-1:0]  pwdata,
    output logic [itp_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output itp_pkg::t_cfg               o_cfg
);

    localparam logic [1:0] REG_PIVOT_COL = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_CHECK     = 2'd2;
    localparam logic [1:0] REG_SKIP      = 2'd3;

    itp_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[itp_pkg::CFG_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pivot_col      <= 5'd1;
            r_cfg.rows_in_use    <= 7'd64;
            r_cfg.ovf_detect     <= 1'b1;
            r_cfg.skip_zero_rows <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PIVOT_COL: r_cfg.pivot_col      <= pwdata[4:0];
                REG_ROWS:      r_cfg.rows_in_use    <= pwdata[6:0];
                REG_CHECK:     r_cfg.ovf_detect     <= pwdata[0];
                REG_SKIP:      r_cfg.skip_zero_rows <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PIVOT_COL: prdata = itp_pkg::CFG_DW'(r_cfg.pivot_col);
            REG_ROWS:      prdata = itp_pkg::CFG_DW'(r_cfg.rows_in_use);
            REG_CHECK:     prdata = itp_pkg::CFG_DW'(r_cfg.ovf_detect);
            REG_SKIP:      prdata = itp_pkg::CFG_DW'(r_cfg.skip_zero_rows);
            default:       prdata = '0;
        endcase
    end

endmodule

[hdl/itp_lane_alu.sv]
// Two-stage lane datapath: products, then wrap, sum and overflow detect.
module itp_lane_alu #(
    parameter int IDX_W = $clog2(itp_pkg::ROW_LEN_DEF)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itp_pkg::t_lane_op     i_op,
    input  logic [IDX_W-1:0]      i_idx,
    output itp_pkg::t_lane_out    o_res,
    output logic [IDX_W-1:0]      o_idx
);

    logic               r_v;
    logic               r_ovr;
    logic [IDX_W-1:0]   r_idx;
    logic signed [31:0] r_m0;
    logic signed [31:0] r_m1;
    logic signed [31:0] r_cp;
    logic signed [16:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_op.v;
        end
        r_ovr <= i_op.ovr;
        r_idx <= i_idx;
        r_m0  <= i_op.c * i_op.pj;
        r_m1  <= i_op.x * i_op.a;
        r_cp  <= i_op.cp;
    end

    // both terms are wrapped before the add, as the row update does
    assign sum = {r_m0[15], r_m0[15:0]} + {r_m1[15], r_m1[15:0]};

    assign o_idx     = r_idx;
    assign o_res.v   = r_v;
    assign o_res.res = r_ovr ? r_cp[15:0] : sum[15:0];
    assign o_res.ovf = itp_pkg::out16(r_m0) || itp_pkg::out16(r_m1) || (sum[16] != sum[15]);

endmodule

[hdl/itp_emit.sv]
// Output side: reads a finished row from the row memory into a small queue.
`include "integer_tableau_pivot_defines.svh"
module itp_emit #(
    parameter int ROW_LEN = itp_pkg::ROW_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  itp_pkg::t_emit_meta                 i_meta,
    output logic                                o_rd_en,
    output logic [$clog2(ROW_LEN)-1:0]          o_rd_addr,
    input  logic signed [15:0]                  i_rd_data,
    output logic                                o_busy,
    output logic [$clog2(ROW_LEN+1)-1:0]        o_issued,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output itp_pkg::t_out_item                  o_out_data
);

    localparam int IDX_W = $clog2(ROW_LEN);
    localparam int CNT_W = $clog2(ROW_LEN+1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_LEN - 1);
    localparam logic [1:0] Q_LAST = 2'd2;

    logic                r_busy;
    logic [CNT_W-1:0]    r_issued;
    itp_pkg::t_emit_meta r_meta;
    logic                r_inflight;
    logic [IDX_W-1:0]    r_inf_idx;
    itp_pkg::t_out_item  r_q [3];
    logic [1:0]          r_head;
    logic [1:0]          r_tail;
    logic [1:0]          r_count;
    logic                issue;
    logic                pop;
    itp_pkg::t_out_item  push_item;

    // keep reads in flight plus queued entries within the three slots
    assign issue = r_busy && ((3'(r_count) + 3'(r_inflight)) < 3'd3);
    assign pop   = (r_count != 2'd0) && !i_out_stall;

    assign o_rd_en     = issue;
    assign o_rd_addr   = r_issued[IDX_W-1:0];
    assign o_busy      = r_busy;
    assign o_issued    = r_issued;
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_q[r_head];

    always_comb begin
        push_item.value_out      = i_rd_data;
        push_item.last_of_row    = (r_inf_idx == LAST_IDX);
        push_item.last_of_matrix = (r_inf_idx == LAST_IDX) && r_meta.last_mat;
        push_item.no_overflow    = r_meta.ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issued   <= '0;
            r_inflight <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (i_start) begin
                r_busy   <= 1'b1;
                r_issued <= '0;
                r_meta   <= i_meta;
            end else if (issue) begin
                r_issued <= r_issued + CNT_W'(1);
                if (r_issued[IDX_W-1:0] == LAST_IDX) begin
                    r_busy <= 1'b0;
                end
            end
            r_inflight <= issue;
            r_inf_idx  <= r_issued[IDX_W-1:0];
            if (r_inflight) begin
                r_q[r_tail] <= push_item;
                r_tail      <= (r_tail == Q_LAST) ? 2'd0 : r_tail + 2'd1;
            end
            if (pop) begin
                r_head <= (r_head == Q_LAST) ? 2'd0 : r_head + 2'd1;
            end
            r_count <= r_count + 2'(r_inflight) - 2'(pop);
        end
    end

    `ITP_ASSERT_IMP(a_queue_room, i_clk, i_rst_n, r_inflight, r_count != 2'd3, "output queue overrun")
    `ITP_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "row handed over while busy")

endmodule

[hdl/integer_tableau_pivot.sv]
// Fraction-free integer pivot step: rows stream in one element per transaction
// and are buffered in a row memory. When a row is complete the block runs a
// setup state (S_PREP), then a compute pass (S_CALC) that reads each lane
// from the row memory (and the stored pivot row), runs it through a two-stage
// multiply/add lane unit and writes the result back in place, then a handover
// state (S_HAND) that hands the row to the output queue. Input stalls through
// setup, compute and handover and until the first entry is read out; emitting
// a row overlaps loading of the next one, an element being taken only once its
// entry has been read out. The row memory has a single read port, shared by
// the compute pass and the output side. The no_overflow tag covers every row of
// the matrix up to and including the one it is emitted with.
// No clearing pass follows reset.
`include "integer_tableau_pivot_defines.svh"
module integer_tableau_pivot #(
    parameter int ROW_LEN  = itp_pkg::ROW_LEN_DEF,
    parameter int MAX_ROWS = itp_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  itp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output itp_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itp_pkg::CFG_AW-1:0]  paddr,
    input  logic [itp_pkg::CFG_DW-1:0]  pwdata,
    output logic [itp_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int IDX_W = $clog2(ROW_LEN);
    localparam int CNT_W = $clog2(ROW_LEN + 1);
    localparam int RC_W  = $clog2(MAX_ROWS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_LEN - 1);
    localparam logic signed [15:0] MIN16 = 16'sh8000;

    typedef enum logic [1:0] {
        S_RECV,
        S_PREP,
        S_CALC,
        S_HAND
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_col;
    logic                r_active;
    logic [RC_W-1:0]     r_row_cnt;
    logic signed [15:0]  r_old0;
    logic signed [15:0]  r_oldp;
    logic signed [15:0]  r_scale;
    logic signed [15:0]  r_ppf;
    logic signed [31:0]  r_cp;
    logic                r_ovf;
    logic                r_is_pivot;
    logic                r_skip;
    logic                r_last_mat;
    logic                r_rd_on;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_q_v;
    logic [IDX_W-1:0]    r_q_idx;
    logic signed [15:0]  r_buf_q;
    logic signed [15:0]  r_store_q;
    logic signed [15:0]  r_row_mem [ROW_LEN];
    logic signed [15:0]  r_piv_mem [ROW_LEN];

    itp_pkg::t_cfg       cfg;
    logic [IDX_W-1:0]    p_eff;
    logic [RW-1:0]       rows_eff;
    logic                last_mat_c;
    logic                is_pivot_c;
    logic                skip_c;
    logic signed [15:0]  neg_old0;
    logic signed [15:0]  neg_oldp;
    logic signed [31:0]  cp_full;
    logic                in_start;
    logic [IDX_W-1:0]    wr_col;
    logic                room;
    logic                in_acc;
    logic                in_wr;
    logic [IDX_W-1:0]    buf_addr;
    itp_pkg::t_lane_op   lane_op;
    itp_pkg::t_lane_out  lane_out;
    logic [IDX_W-1:0]    lane_idx;
    itp_pkg::t_emit_meta emit_meta;
    logic                emit_start;
    logic                emit_rd_en;
    logic [IDX_W-1:0]    emit_addr;
    logic                emit_busy;
    logic [CNT_W-1:0]    emit_issued;

    itp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // effective pivot column and row count
    always_comb begin
        if (32'(cfg.pivot_col) >= ROW_LEN) begin
            p_eff = LAST_IDX;
        end else begin
            p_eff = IDX_W'(cfg.pivot_col);
        end
        if (cfg.rows_in_use == '0) begin
            rows_eff = RW'(1);
        end else if (32'(cfg.rows_in_use) > MAX_ROWS) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(cfg.rows_in_use);
        end
    end

    assign last_mat_c = ((RW+1)'(r_row_cnt) + (RW+1)'(1)) >= (RW+1)'(rows_eff);
    assign is_pivot_c = (r_row_cnt == '0);
    assign skip_c     = cfg.skip_zero_rows && (r_oldp == '0);
    assign neg_old0   = -r_old0;
    assign neg_oldp   = -r_oldp;
    assign cp_full    = r_oldp * r_ppf;

    // input side: an element may only land on an entry already read out
    assign in_start   = i_in_data.starts_matrix;
    assign wr_col     = in_start ? '0 : r_col;
    assign room       = !emit_busy || (CNT_W'(wr_col) < emit_issued);
    assign o_in_stall = (r_state != S_RECV) || !room;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_wr      = in_acc && (in_start || r_active);

    assign buf_addr   = (r_state == S_CALC) ? r_rd_idx : emit_addr;

    // lane operands; the pivot row is a signed copy (multiply by +1 or -1) with columns 0 and p replaced
    always_comb begin
        lane_op.v  = r_q_v;
        lane_op.cp = r_cp;
        if (r_is_pivot) begin
            if (r_q_idx == p_eff) begin
                lane_op.x = r_ppf;
            end else if (r_q_idx == '0) begin
                lane_op.x = r_scale;
            end else begin
                lane_op.x = r_buf_q;
            end
            lane_op.a   = r_scale[15] ? -16'sd1 : 16'sd1;
            lane_op.c   = '0;
            lane_op.pj  = '0;
            lane_op.ovr = 1'b0;
        end else begin
            lane_op.x   = r_buf_q;
            lane_op.a   = (r_skip || (r_q_idx == '0)) ? 16'sd1 : r_scale;
            lane_op.c   = r_skip ? 16'sd0 : r_oldp;
            lane_op.pj  = (r_q_idx == '0) ? 16'sd0 : r_store_q;
            lane_op.ovr = !r_skip && (r_q_idx == p_eff);
        end
    end

    itp_lane_alu #(
        .IDX_W (IDX_W)
    ) u_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (lane_op),
        .i_idx   (r_q_idx),
        .o_res   (lane_out),
        .o_idx   (lane_idx)
    );

    assign emit_start         = (r_state == S_HAND);
    assign emit_meta.last_mat = r_last_mat;
    assign emit_meta.ok       = !r_ovf;

    itp_emit #(
        .ROW_LEN (ROW_LEN)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (emit_start),
        .i_meta      (emit_meta),
        .o_rd_en     (emit_rd_en),
        .o_rd_addr   (emit_addr),
        .i_rd_data   (r_buf_q),
        .o_busy      (emit_busy),
        .o_issued    (emit_issued),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (in_wr) begin
            r_row_mem[wr_col] <= i_in_data.value;
        end else if (lane_out.v) begin
            r_row_mem[lane_idx] <= lane_out.res;
        end
        if (lane_out.v && r_is_pivot) begin
            r_piv_mem[lane_idx] <= lane_out.res;
        end
        r_buf_q   <= r_row_mem[buf_addr];
        r_store_q <= r_piv_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RECV;
            r_col     <= '0;
            r_active  <= 1'b0;
            r_row_cnt <= '0;
            r_ovf     <= 1'b0;
            r_rd_on   <= 1'b0;
            r_rd_idx  <= '0;
            r_q_v     <= 1'b0;
        end else begin
            case (r_state)
                S_RECV: begin
                    if (in_acc && in_start) begin
                        r_active  <= 1'b1;
                        r_row_cnt <= '0;
                        r_ovf     <= 1'b0;
                    end
                    if (in_wr) begin
                        if (wr_col == '0) begin
                            r_old0 <= i_in_data.value;
                        end
                        if (wr_col == p_eff) begin
                            r_oldp <= i_in_data.value;
                        end
                        if (wr_col == LAST_IDX) begin
                            r_col   <= '0;
                            r_state <= S_PREP;
                        end else begin
                            r_col <= wr_col + IDX_W'(1);
                        end
                    end
                end
                S_PREP: begin
                    r_is_pivot <= is_pivot_c;
                    r_skip     <= !is_pivot_c && skip_c;
                    r_last_mat <= last_mat_c;
                    r_cp       <= cp_full;
                    if (is_pivot_c) begin
                        r_ppf   <= neg_old0;
                        r_scale <= (p_eff == '0) ? neg_old0 : neg_oldp;
                        if (cfg.ovf_detect && ((r_old0 == MIN16) || (r_oldp == MIN16))) begin
                            r_ovf <= 1'b1;
                        end
                    end else if (cfg.ovf_detect && !skip_c && itp_pkg::out16(cp_full)) begin
                        r_ovf <= 1'b1;
                    end
                    if (last_mat_c) begin
                        r_active <= 1'b0;
                    end else begin
                        r_row_cnt <= r_row_cnt + RC_W'(1);
                    end
                    r_rd_on  <= 1'b1;
                    r_rd_idx <= '0;
                    r_state  <= S_CALC;
                end
                S_CALC: begin
                    if (r_rd_on) begin
                        r_rd_idx <= r_rd_idx + IDX_W'(1);
                        if (r_rd_idx == LAST_IDX) begin
                            r_rd_on <= 1'b0;
                        end
                    end
                    if (lane_out.v && lane_out.ovf && cfg.ovf_detect) begin
                        r_ovf <= 1'b1;
                    end
                    if (lane_out.v && (lane_idx == LAST_IDX)) begin
                        r_state <= S_HAND;
                    end
                end
                S_HAND: begin
                    r_state <= S_RECV;
                end
                default: begin
                    r_state <= S_RECV;
                end
            endcase
            r_q_v   <= (r_state == S_CALC) && r_rd_on;
            r_q_idx <= r_rd_idx;
        end
    end

    `ITP_ASSERT_IMP(a_row_done_drained, i_clk, i_rst_n, in_wr && (wr_col == LAST_IDX), !emit_busy, "row completed before previous row was read out")
    `ITP_ASSERT_NXT(a_hand_starts_emit, i_clk, i_rst_n, r_state == S_HAND, emit_busy, "row handover did not start output")
    `ITP_ASSERT_IMP(a_port_exclusive, i_clk, i_rst_n, r_state == S_CALC, !emit_rd_en, "output read during compute pass")

endmodule

[sim/tb_integer_tableau_pivot.sv]
// Testbench for integer_tableau_pivot: streams matrices, predicts each pivot step, checks results.
`timescale 1ns / 1ps
module tb_integer_tableau_pivot;

    localparam int ROW_LEN       = itp_pkg::ROW_LEN_DEF;
    localparam int MAX_ROWS      = itp_pkg::MAX_ROWS_DEF;
    localparam int REG_PIVOT_COL = 0;
    localparam int REG_ROWS      = 1;
    localparam int REG_CHECK_OVF = 2;
    localparam int REG_SKIP_ZERO = 3;
    localparam int RANDOM_ITEMS  = 150;
    localparam int DRAIN_CYCLES  = 3 * (2 * ROW_LEN + 5);
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 10_000_000;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    itp_pkg::t_in_item          i_in_data  = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    itp_pkg::t_out_item         o_out_data;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [itp_pkg::CFG_AW-1:0] paddr   = '0;
    logic [itp_pkg::CFG_DW-1:0] pwdata  = '0;
    logic [itp_pkg::CFG_DW-1:0] prdata;
    logic                       pready;

    integer_tableau_pivot DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the configuration and of the pivot state.
    logic [4:0]         cfg_pivot = 5'd1;
    logic [6:0]         cfg_rows  = 7'd64;
    logic               cfg_chk   = 1'b1;
    logic               cfg_skip  = 1'b0;
    logic signed [15:0] pivot_row [ROW_LEN];
    logic signed [15:0] row_buf [ROW_LEN];
    int                 col_cnt   = 0;
    int                 row_idx   = 0;
    logic signed [15:0] scale_a   = '0;
    logic signed [15:0] factor    = '0;
    bit                 ovf_sticky = 1'b0;
    bit                 in_matrix  = 1'b0;

    itp_pkg::t_out_item expected_elems[$];
    itp_pkg::t_in_item  elem_queue[$];

    logic [15:0] corner_vals [7] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                                     16'hFFFF, 16'h5555, 16'hAAAA};

    int n_pushed   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_random   = 0;
    int n_noise    = 0;
    int n_settings = 0;

    function automatic void flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic string fmt_elem(input itp_pkg::t_out_item e);
        return $sformatf("value=%0d last_row=%0b last_mat=%0b no_ovf=%0b",
                         e.value_out, e.last_of_row, e.last_of_matrix, e.no_overflow);
    endfunction

    // Wrap to 16 bits, flagging overflow when detection is on.
    function automatic logic signed [15:0] fit16(input int x);
        if (cfg_chk && (x < -32768 || x > 32767))
            ovf_sticky = 1'b1;
        return 16'(x);
    endfunction

    function automatic void pivot_step_predict(input itp_pkg::t_in_item it);
        int                 p;
        int                 rows;
        int                 c;
        int                 old0;
        int                 oldp;
        int                 j;
        logic signed [15:0] res [ROW_LEN];
        logic signed [15:0] m0;
        logic signed [15:0] m1;
        bit                 last_m;
        itp_pkg::t_out_item o;
        p = (cfg_pivot >= ROW_LEN) ? ROW_LEN - 1 : int'(cfg_pivot);
        rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows));
        if (it.starts_matrix) begin
            in_matrix  = 1'b1;
            row_idx    = 0;
            col_cnt    = 0;
            ovf_sticky = 1'b0;
        end
        if (!in_matrix)
            return;
        row_buf[col_cnt] = it.value;
        if (col_cnt < ROW_LEN - 1) begin
            col_cnt++;
            return;
        end
        col_cnt = 0;

        if (row_idx == 0) begin
            old0 = row_buf[0];
            oldp = row_buf[p];
            if (cfg_chk && (old0 == -32768 || oldp == -32768))
                ovf_sticky = 1'b1;
            res    = row_buf;
            res[0] = 16'(-oldp);
            res[p] = 16'(-old0);
            factor  = 16'(-old0);
            scale_a = res[0];
            if (res[0] < 0) begin
                for (j = 0; j < ROW_LEN; j++)
                    res[j] = fit16(-int'(res[j]));
            end
            pivot_row = res;
        end else begin
            c = row_buf[p];
            if (cfg_skip && c == 0) begin
                res = row_buf;
            end else begin
                for (j = 0; j < ROW_LEN; j++) begin
                    m0 = fit16(c * ((j == 0) ? 0 : int'(pivot_row[j])));
                    m1 = fit16(int'(row_buf[j]) * ((j == 0) ? 1 : int'(scale_a)));
                    res[j] = fit16(int'(m0) + int'(m1));
                end
                res[p] = fit16(c * int'(factor));
            end
        end

        last_m = (row_idx + 1 >= rows);
        for (j = 0; j < ROW_LEN; j++) begin
            o.value_out      = res[j];
            o.last_of_row    = (j == ROW_LEN - 1);
            o.last_of_matrix = (j == ROW_LEN - 1) && last_m;
            o.no_overflow    = !ovf_sticky;
            expected_elems.push_back(o);
        end
        if (last_m)
            in_matrix = 1'b0;
        else
            row_idx++;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pivot_step_predict(i_in_data);
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (elem_queue.size() > 0) begin
                    i_in_data  <= elem_queue.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transaction, stalls in modes that change every so often.
    int stall_mode = 0;
    int stall_run  = 0;
    int cyc        = 0;

    always @(posedge i_clk) begin
        itp_pkg::t_out_item want;
        itp_pkg::t_out_item got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (expected_elems.size() == 0) begin
                    flag_error($sformatf("unexpected result %s", fmt_elem(got)));
                end else begin
                    want = expected_elems.pop_front();
                    if (got.value_out !== want.value_out ||
                        got.last_of_row !== want.last_of_row ||
                        got.last_of_matrix !== want.last_of_matrix ||
                        got.no_overflow !== want.no_overflow)
                        flag_error($sformatf("result %0d: expected %s, got %s",
                                             n_checked, fmt_elem(want), fmt_elem(got)));
                end
                n_checked++;
            end
            cyc++;
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(20, 120);
            end
            stall_run--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ((cyc % 5) < 2);
                default: i_out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    task automatic cfg_write(input int idx, input logic [itp_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= itp_pkg::CFG_AW'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read(input int idx, output logic [itp_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= itp_pkg::CFG_AW'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input int pc, input int rows, input int chk, input int skip);
        logic [itp_pkg::CFG_DW-1:0] vals [4];
        logic [itp_pkg::CFG_DW-1:0] masks [4];
        logic [itp_pkg::CFG_DW-1:0] rd;
        int                         i;
        vals  = '{pc, rows, chk, skip};
        masks = '{32'h1F, 32'h7F, 32'h1, 32'h1};
        for (i = REG_PIVOT_COL; i <= REG_SKIP_ZERO; i++)
            cfg_write(i, vals[i] & masks[i]);
        for (i = REG_PIVOT_COL; i <= REG_SKIP_ZERO; i++) begin
            cfg_read(i, rd);
            if (rd !== (vals[i] & masks[i]))
                flag_error($sformatf("register %0d read back %0h, wrote %0h",
                                     i, rd, vals[i] & masks[i]));
        end
        cfg_pivot = pc[4:0];
        cfg_rows  = rows[6:0];
        cfg_chk   = chk[0];
        cfg_skip  = skip[0];
        n_settings++;
    endtask

    function automatic void push_elem(input logic [15:0] v, input bit s);
        itp_pkg::t_in_item it;
        it.value         = v;
        it.starts_matrix = s;
        elem_queue.push_back(it);
        n_pushed++;
    endfunction

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return corner_vals[$urandom_range(0, 6)];
        if (r < 20)
            return 16'h0000;
        if (r < 70)
            return 16'($urandom_range(0, 200) - 100);
        return 16'($urandom);
    endfunction

    // Queue one matrix, or its first n_cut elements when n_cut > 0.
    function automatic void push_matrix(input int rows_eff, input int p, input int n_cut);
        int          total;
        int          k;
        logic [15:0] v;
        total = (n_cut > 0) ? n_cut : rows_eff * ROW_LEN;
        for (k = 0; k < total; k++) begin
            v = pick_value();
            // zero c rows show up often enough to exercise the copy path
            if (k >= ROW_LEN && (k % ROW_LEN) == p && $urandom_range(0, 3) == 0)
                v = 16'h0000;
            push_elem(v, k == 0);
        end
        n_random += total;
    endfunction

    function automatic void push_phase(input int n_mats);
        int rows_eff;
        int m;
        int k;
        rows_eff = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows));
        for (m = 0; m < n_mats; m++) begin
            if ($urandom_range(0, 4) == 0)
                push_matrix(rows_eff, int'(cfg_pivot),
                            $urandom_range(1, rows_eff * ROW_LEN - 1));
            push_matrix(rows_eff, int'(cfg_pivot), 0);
            if ($urandom_range(0, 2) == 0) begin
                for (k = $urandom_range(1, 3); k > 0; k--) begin
                    push_elem(pick_value(), 1'b0);
                    n_noise++;
                end
            end
        end
    endfunction

    // Block is idle once every element is taken, every result is back and the
    // pipeline has had time to finish rows that produce nothing.
    task automatic wait_until_settled();
        while (n_accepted != n_pushed || expected_elems.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int j;
        int k;
        int ph;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // elements without a matrix start after reset are dropped
        push_elem(16'h8000, 1'b0);
        push_elem(16'h7FFF, 1'b0);
        push_elem(16'h0001, 1'b0);
        n_noise += 3;
        wait_until_settled();

        apply_settings(31, 2, 1, 1);
        // most-negative column 0 in the pivot row: negate overflows, row flips sign
        for (j = 0; j < ROW_LEN; j++)
            push_elem((j == 0) ? 16'h8000 : (j == 31) ? 16'h0007 : corner_vals[j % 7], j == 0);
        // c of zero with skipping on: row comes back untouched
        for (j = 0; j < ROW_LEN; j++)
            push_elem((j == 31) ? 16'h0000 : corner_vals[(j + 3) % 7], 1'b0);
        // restart partway through the second row
        for (k = 0; k < 40; k++)
            push_elem(16'(k * 3 - 50), k == 0);
        for (j = 0; j < ROW_LEN; j++)
            push_elem((j == 0) ? 16'h0003 : (j == 31) ? 16'hFFFE : 16'(j - 16), j == 0);
        for (j = 0; j < ROW_LEN; j++)
            push_elem((j == 31) ? 16'h8000 : corner_vals[j % 7], 1'b0);
        wait_until_settled();

        ph = 0;
        while (n_random < RANDOM_ITEMS) begin
            case (ph)
                0: apply_settings(0, 0, 1, 0);
                1: apply_settings(1, 2, 0, 1);
                2: apply_settings(31, 1, 1, 1);
                default: apply_settings($urandom_range(0, 31), $urandom_range(1, 2),
                                        $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            push_phase($urandom_range(1, 2));
            wait_until_settled();
            ph++;
        end

        // row count above the maximum clamps; the first rows of such a matrix
        // must not be flagged as its end
        apply_settings($urandom_range(1, 30), 127, $urandom_range(0, 1), $urandom_range(0, 1));
        push_matrix(MAX_ROWS, int'(cfg_pivot), ROW_LEN + ROW_LEN / 2);
        wait_until_settled();

        if (expected_elems.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_elems.size()));
        $display("Covered %0d settings, %0d elements in (%0d random, %0d idle), %0d results",
                 n_settings, n_accepted, n_random, n_noise, n_checked);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d of %0d elements taken, %0d results outstanding",
                 n_accepted, n_pushed, expected_elems.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
